>>> design/ir_med_pkg.sv
package ir_med_pkg;

    // Field and register widths
    localparam int INTERVAL_W = 16;
    localparam int TOL_W      = 8;
    localparam int CMD_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Frame layout
    localparam int FRAME_BITS_DEF = 14;
    localparam int TOGGLE_INDEX   = 2;

    // Register reset values
    localparam logic [INTERVAL_W-1:0] LONG_RESET  = 16'd58;
    localparam logic [INTERVAL_W-1:0] SHORT_RESET = 16'd29;
    localparam logic [TOL_W-1:0]      TOL_RESET   = 8'd10;

    typedef logic [INTERVAL_W-1:0] t_interval;
    typedef logic [TOL_W-1:0]      t_tol;
    typedef logic [CMD_W-1:0]      t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG  = 2'd0,
        CFG_SHORT = 2'd1,
        CFG_TOL   = 2'd2
    } t_cfg_index;

    // Open window: nom - tol < c < nom + tol, no wrap
    function automatic logic in_window(t_interval c, t_interval nom, t_tol tol);
        logic [INTERVAL_W:0] hi;
        logic [INTERVAL_W:0] lo;
        hi = {1'b0, nom} + {{(INTERVAL_W+1-TOL_W){1'b0}}, tol};
        lo = {1'b0, c} + {{(INTERVAL_W+1-TOL_W){1'b0}}, tol};
        return ({1'b0, c} < hi) && (lo > {1'b0, nom});
    endfunction

endpackage

>>> design/ir_manchester_edge_decoder.sv
// Manchester IR frame decoder working from edge timing.
//
// Input channel (i_in_valid / o_in_ready): one item per IR edge, carrying the
// timer count since the previous edge in i_edge_interval.
// Output channel (o_out_valid / i_out_ready): one item per completed frame
// whose toggle bit differs from the previous accepted frame, carrying the
// six command bits and the toggle bit.
// Config port: i_cfg_we with i_cfg_index selects long interval (0), short
// interval (1) or window tolerance (2); other indexes are ignored. Write only
// while the block is idle.
//
// An accepted item is held in the input register and is classified and folded
// into the frame state when it advances, once the output register is empty or
// being taken; a frame's result enters the output register as it advances.
// Throughput is one item per cycle while the output is not stalled, set by the
// combinational window compare and state update between input and output register.
// Reset (synchronous, active low) restores the register defaults, sets the
// level to one and clears the bit count, pending half edge and toggle memory.
// When the receiver stalls, the output register holds its item and the input
// register still takes one more item; o_in_ready drops only once both are full.
module ir_manchester_edge_decoder #(
    parameter int FRAME_BITS = ir_med_pkg::FRAME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ir_med_pkg::INTERVAL_W-1:0] i_edge_interval,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ir_med_pkg::CMD_W-1:0]    o_command_code,
    output logic                            o_toggle_bit,
    input  logic                            i_cfg_we,
    input  logic [ir_med_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ir_med_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ir_med_pkg::*;

    localparam int CNT_W = $clog2(FRAME_BITS + 1);
    localparam int IDX_W = $clog2(FRAME_BITS);

    // Configuration registers
    t_interval r_long;
    t_interval r_short;
    t_tol      r_tol;

    // Input register
    logic      r_item_vld;
    t_interval r_item;

    // Frame state
    logic                  r_level;
    logic                  r_half;
    logic [CNT_W-1:0]      r_count;
    logic [FRAME_BITS-1:0] r_frame;
    logic                  r_last_toggle;

    // Output register
    logic r_out_vld;
    t_cmd r_cmd;
    logic r_toggle;

    logic                  n_level;
    logic                  n_half;
    logic [CNT_W-1:0]      n_count;
    logic [FRAME_BITS-1:0] n_frame;
    logic                  n_last_toggle;
    t_cmd                  n_cmd;
    logic                  n_toggle;
    logic                  emit;
    logic                  advance;
    logic                  in_accept;

    // Process the held item when the output register can take its result
    assign advance    = r_item_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_item_vld || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long  <= LONG_RESET;
            r_short <= SHORT_RESET;
            r_tol   <= TOL_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LONG:  r_long  <= i_cfg_data;
                CFG_SHORT: r_short <= i_cfg_data;
                CFG_TOL:   r_tol   <= i_cfg_data[TOL_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
        end else if (in_accept) begin
            r_item_vld <= 1'b1;
        end else if (advance) begin
            r_item_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_edge_interval;
        end
    end

    // Classify the edge and fold it into the frame
    always_comb begin
        logic             store;
        logic             store_val;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] cnt_inc;
        n_level       = r_level;
        n_half        = r_half;
        n_frame       = r_frame;
        n_last_toggle = r_last_toggle;
        store         = 1'b0;
        store_val     = r_level;
        pos           = r_count;
        emit          = 1'b0;

        if (in_window(r_item, r_long, r_tol)) begin
            // Full-bit interval: invert the level and store it
            n_level   = ~r_level;
            store     = 1'b1;
            store_val = ~r_level;
            n_half    = 1'b0;
        end else if (in_window(r_item, r_short, r_tol)) begin
            // Half-bit interval: store on every second one
            if (!r_half) begin
                n_half = 1'b1;
            end else begin
                store  = 1'b1;
                n_half = 1'b0;
            end
        end else begin
            // Out-of-window interval: start a new frame with bit 0 = 1
            n_level   = 1'b1;
            store     = 1'b1;
            store_val = 1'b1;
            pos       = '0;
        end

        cnt_inc = pos + CNT_W'(1);
        n_count = store ? cnt_inc : r_count;
        if (store) begin
            n_frame[pos[IDX_W-1:0]] = store_val;
        end

        // Frame complete: rearm and report on a toggle change
        if (n_count == CNT_W'(FRAME_BITS)) begin
            n_level = 1'b1;
            n_count = '0;
            if (n_frame[TOGGLE_INDEX] != r_last_toggle) begin
                emit          = 1'b1;
                n_last_toggle = n_frame[TOGGLE_INDEX];
            end
        end
    end

    // First received command bit lands in the MSB
    always_comb begin
        for (int k = 0; k < CMD_W; k++) begin
            n_cmd[CMD_W-1-k] = n_frame[FRAME_BITS-CMD_W+k];
        end
        n_toggle = n_frame[TOGGLE_INDEX];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level       <= 1'b1;
            r_half        <= 1'b0;
            r_count       <= '0;
            r_last_toggle <= 1'b0;
        end else if (advance) begin
            r_level       <= n_level;
            r_half        <= n_half;
            r_count       <= n_count;
            r_last_toggle <= n_last_toggle;
        end
    end

    // Frame bits need no reset: every bit is written before a frame closes
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_frame <= n_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= emit;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_cmd    <= n_cmd;
            r_toggle <= n_toggle;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_command_code = r_cmd;
    assign o_toggle_bit   = r_toggle;

endmodule

>>> design/ir_med_chk.sv
module ir_med_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [ir_med_pkg::CMD_W-1:0]      o_command_code,
    input logic                              o_toggle_bit
);

    // Hold a stalled output item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_command_code) && $stable(o_toggle_bit))
        else $error("output payload changed while stalled");

    // Input backpressure only when the output is full and stalled
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    // Once blocked, the input stays blocked until the receiver takes its item
    a_ready_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready && !i_out_ready |=> (!o_in_ready || i_out_ready))
        else $error("input reopened while both registers stayed full");

endmodule

bind ir_manchester_edge_decoder ir_med_chk u_ir_med_chk (.*);
